FILE: rtl/lfd_pkg.sv
// ----------------------------------------------------------------------------
// lfd_pkg
// shared types and constants for the lighting frame deframer
// ----------------------------------------------------------------------------
`default_nettype none

package lfd_pkg;

	localparam int NUM_CHANNELS   = 16;
	localparam int NUM_STRIPS     = 4;
	localparam int MAX_STRIP_LEDS = 1024;

	localparam int LEN_W = 11;  // strip length register width
	localparam int LED_W = 10;  // led position width
	localparam int CH_W  = 4;   // channel number width
	localparam int ST_W  = 2;   // strip number width

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_STRIP_LEDS);

	// configuration register indexes
	localparam logic [2:0] CFG_MASK = 3'd0;
	localparam logic [2:0] CFG_LEN0 = 3'd1;
	localparam logic [2:0] CFG_LEN1 = 3'd2;
	localparam logic [2:0] CFG_LEN2 = 3'd3;
	localparam logic [2:0] CFG_LEN3 = 3'd4;

	typedef enum logic [2:0] {
		PH_TIME,
		PH_FADE,
		PH_CHAN,
		PH_STRIP,
		PH_CSUM
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER,
		KIND_CHAN,
		KIND_STRIP,
		KIND_STATUS
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_BAD_SUM,
		STAT_END,
		STAT_SHORT
	} status_t;

	// outcome of the next channel / strip search
	typedef struct packed {
		phase_t          ph;
		logic [CH_W-1:0] chan;
		logic [ST_W-1:0] strip;
	} seek_t;

	typedef struct packed {
		kind_t            kind;
		logic [31:0]      timestamp;
		logic             fade;
		logic [3:0]       group_index;
		logic [LED_W-1:0] led_index;
		logic [7:0]       green;
		logic [7:0]       red;
		logic [7:0]       blue;
		status_t          status;
		logic [31:0]      computed_sum;
	} rec_t;

endpackage

`default_nettype wire

FILE: rtl/lfd_seek.sv
// ----------------------------------------------------------------------------
// lfd_seek
// priority search for the next enabled channel or non-empty strip
// ----------------------------------------------------------------------------
`default_nettype none

module lfd_seek
	import lfd_pkg::*;
(
	input  wire logic [NUM_CHANNELS-1:0] chan_mask,
	input  wire logic [LEN_W-1:0]        strip_len [NUM_STRIPS],
	input  wire logic                    from_chan,   // search channels first
	input  wire logic [CH_W:0]           chan_from,
	input  wire logic [ST_W:0]           strip_from,
	output seek_t                        seek
);

	logic            chan_hit;
	logic [CH_W-1:0] chan_idx;
	logic            strip_hit;
	logic [ST_W-1:0] strip_idx;
	logic [ST_W:0]   strip_base;

	assign strip_base = from_chan ? '0 : strip_from;

	// scan high to low so the lowest match wins
	always_comb begin
		chan_hit = 1'b0;
		chan_idx = '0;
		for (int c = NUM_CHANNELS - 1; c >= 0; c--) begin
			if (chan_mask[c] && ((CH_W+1)'(c) >= chan_from)) begin
				chan_hit = 1'b1;
				chan_idx = CH_W'(c);
			end
		end
	end

	always_comb begin
		strip_hit = 1'b0;
		strip_idx = '0;
		for (int s = NUM_STRIPS - 1; s >= 0; s--) begin
			if ((strip_len[s] != '0) && ((ST_W+1)'(s) >= strip_base)) begin
				strip_hit = 1'b1;
				strip_idx = ST_W'(s);
			end
		end
	end

	always_comb begin
		seek.chan  = chan_idx;
		seek.strip = strip_idx;
		if (from_chan && chan_hit) begin
			seek.ph = PH_CHAN;
		end else if (strip_hit) begin
			seek.ph = PH_STRIP;
		end else begin
			seek.ph = PH_CSUM;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lfd_out_reg.sv
// ----------------------------------------------------------------------------
// lfd_out_reg
// result register between the parser and the output stream
// ----------------------------------------------------------------------------
`default_nettype none

module lfd_out_reg
	import lfd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  wire rec_t rec_in,
	output logic      can_take,   // register free or emptied this cycle
	output logic      out_valid,
	input  wire logic out_ready,
	output rec_t      rec_out
);

	logic valid_q;
	rec_t rec_q;

	assign can_take  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign rec_out   = rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_q <= rec_in;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/led_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// led_frame_deframer_core
// byte stream parser for lighting frames: header, pixel and status records
// ----------------------------------------------------------------------------
//
// channel   direction  signals                        request
// s_axis    in         tvalid tready tdata tlast      one stream byte or stream end
// m_axis    out        tvalid tready tdata tuser      one record
// cfg       in         cfg_we cfg_index cfg_data      one register write
//
// one byte per cycle when not stalled; each byte is parsed in the cycle it is
// accepted and any record it causes sits in the output register on the next cycle
// s_axis_tready drops only while a record waits in the output register and
// m_axis_tready is low
// reset clears all frame state and configuration; parsing starts at a frame
// start
// the channel and strip searches are combinational priority encoders
// ----------------------------------------------------------------------------
`default_nettype none

module led_frame_deframer_core
	import lfd_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,

	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,   // data_byte
	input  wire logic         s_axis_tlast,   // stream_end

	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// timestamp[31:0] fade[32] group_index[36:33] led_index[46:37] green[54:47]
	// red[62:55] blue[70:63] status[72:71] computed_sum[104:73] zero[111:105]
	output logic [111:0]      m_axis_tdata,
	output logic [1:0]        m_axis_tuser,   // record_kind

	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [15:0]  cfg_data
);

	// configuration
	logic [NUM_CHANNELS-1:0] mask_q;
	logic [LEN_W-1:0]        len_q [NUM_STRIPS];

	// frame state
	phase_t           phase_q;
	logic [1:0]       cnt_q;      // byte within field or triple
	logic [CH_W-1:0]  chan_q;
	logic [ST_W-1:0]  strip_q;
	logic [LED_W-1:0] led_q;
	logic [31:0]      shift_q;
	logic [31:0]      sum_q;
	logic [7:0]       green_q;
	logic [7:0]       red_q;

	logic  take;
	logic  can_take;
	logic  emit;
	rec_t  rec;
	rec_t  rec_out;
	seek_t seek;

	logic [7:0]       b;
	logic [31:0]      sum_next;
	logic [31:0]      shift_next;
	logic [LEN_W-1:0] cur_len;
	logic [LEN_W-1:0] eff_len;
	logic [LEN_W-1:0] led_plus;

	assign s_axis_tready = can_take;
	assign take          = s_axis_tvalid && can_take;

	assign b          = s_axis_tdata;
	assign sum_next   = sum_q + {24'd0, b};
	assign shift_next = {b, shift_q[31:8]};
	assign cur_len    = len_q[strip_q];
	assign eff_len    = (cur_len > MAX_LEN) ? MAX_LEN : cur_len;
	assign led_plus   = {1'b0, led_q} + LEN_W'(1);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			for (int s = 0; s < NUM_STRIPS; s++) begin
				len_q[s] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MASK: mask_q   <= cfg_data[NUM_CHANNELS-1:0];
				CFG_LEN0: len_q[0] <= cfg_data[LEN_W-1:0];
				CFG_LEN1: len_q[1] <= cfg_data[LEN_W-1:0];
				CFG_LEN2: len_q[2] <= cfg_data[LEN_W-1:0];
				CFG_LEN3: len_q[3] <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// next channel search: from 0 after the fade byte, from the one after
	// the current channel after a channel triple, else strips only
	lfd_seek u_seek (
		.chan_mask  (mask_q),
		.strip_len  (len_q),
		.from_chan  (phase_q != PH_STRIP),
		.chan_from  ((phase_q == PH_CHAN) ? ({1'b0, chan_q} + (CH_W+1)'(1)) : '0),
		.strip_from ({1'b0, strip_q} + (ST_W+1)'(1)),
		.seek       (seek)
	);

	// record for the accepted request
	always_comb begin
		emit = 1'b0;
		rec  = '0;
		if (s_axis_tlast) begin
			emit              = 1'b1;
			rec.kind          = KIND_STATUS;
			rec.status        = (phase_q == PH_TIME && cnt_q == 2'd0) ? STAT_END : STAT_SHORT;
			rec.computed_sum  = sum_q;
		end else begin
			case (phase_q)
				PH_FADE: begin
					emit          = 1'b1;
					rec.kind      = KIND_HEADER;
					rec.timestamp = shift_q;
					rec.fade      = (b != 8'd0);
				end
				PH_CHAN, PH_STRIP: begin
					if (cnt_q == 2'd2) begin
						emit  = 1'b1;
						rec.green = green_q;
						rec.red   = red_q;
						rec.blue  = b;
						if (phase_q == PH_CHAN) begin
							rec.kind        = KIND_CHAN;
							rec.group_index = chan_q;
						end else begin
							rec.kind        = KIND_STRIP;
							rec.group_index = {2'b00, strip_q};
							rec.led_index   = led_q;
						end
					end
				end
				PH_CSUM: begin
					if (cnt_q == 2'd3) begin
						emit             = 1'b1;
						rec.kind         = KIND_STATUS;
						rec.status       = (shift_next == sum_q) ? STAT_OK : STAT_BAD_SUM;
						rec.computed_sum = sum_q;
					end
				end
				default: ;
			endcase
		end
	end

	// frame state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TIME;
			cnt_q   <= '0;
			chan_q  <= '0;
			strip_q <= '0;
			led_q   <= '0;
			shift_q <= '0;
			sum_q   <= '0;
			green_q <= '0;
			red_q   <= '0;
		end else if (take) begin
			if (s_axis_tlast || (phase_q == PH_CSUM && cnt_q == 2'd3)) begin
				// frame done: back to frame start
				phase_q <= PH_TIME;
				cnt_q   <= '0;
				chan_q  <= '0;
				strip_q <= '0;
				led_q   <= '0;
				shift_q <= '0;
				sum_q   <= '0;
				green_q <= '0;
				red_q   <= '0;
			end else begin
				case (phase_q)
					PH_TIME: begin
						sum_q   <= sum_next;
						shift_q <= shift_next;
						cnt_q   <= cnt_q + 2'd1;
						if (cnt_q == 2'd3) begin
							phase_q <= PH_FADE;
						end
					end
					PH_FADE: begin
						sum_q   <= sum_next;
						cnt_q   <= '0;
						shift_q <= '0;
						phase_q <= seek.ph;
						if (seek.ph == PH_CHAN) begin
							chan_q <= seek.chan;
						end
						if (seek.ph == PH_STRIP) begin
							strip_q <= seek.strip;
							led_q   <= '0;
						end
					end
					PH_CHAN, PH_STRIP: begin
						sum_q <= sum_next;
						case (cnt_q)
							2'd0: begin
								green_q <= b;
								cnt_q   <= 2'd1;
							end
							2'd1: begin
								red_q <= b;
								cnt_q <= 2'd2;
							end
							default: begin
								cnt_q <= '0;
								if (phase_q == PH_STRIP && led_plus < eff_len) begin
									led_q <= led_plus[LED_W-1:0];
								end else begin
									// move on to the next channel or strip
									phase_q <= seek.ph;
									if (seek.ph == PH_CHAN) begin
										chan_q <= seek.chan;
									end
									if (seek.ph == PH_STRIP) begin
										strip_q <= seek.strip;
										led_q   <= '0;
									end
								end
							end
						endcase
					end
					PH_CSUM: begin
						shift_q <= shift_next;
						cnt_q   <= cnt_q + 2'd1;
					end
					default: ;
				endcase
			end
		end
	end

	lfd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take && emit),
		.rec_in    (rec),
		.can_take  (can_take),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.rec_out   (rec_out)
	);

	assign m_axis_tuser = rec_out.kind;
	assign m_axis_tdata = {7'd0, rec_out.computed_sum, rec_out.status, rec_out.blue,
		rec_out.red, rec_out.green, rec_out.led_index, rec_out.group_index,
		rec_out.fade, rec_out.timestamp};

endmodule

`default_nettype wire
